/* hdl/isqrt_pkg.sv */
// shared types and constants for the rounded integer square root
// no dependencies; used by every module of the block

package isqrt_pkg;

    // radicand width in use, lower bits of the radicand port
    localparam int RADICAND_WIDTH = 64;
    // width of the radicand port and of the root port
    localparam int RADICAND_PORT_WIDTH = 64;
    localparam int ROOT_PORT_WIDTH = 32;
    // number of root bits, one per iteration
    localparam int ROOT_WIDTH = (RADICAND_WIDTH + 1) / 2;
    localparam int ITER_WIDTH = (ROOT_WIDTH > 1) ? $clog2(ROOT_WIDTH) : 1;

    // weight of the first trial bit, 4^(ROOT_WIDTH-1)
    localparam logic [RADICAND_WIDTH-1:0] BIT_START =
        {{(RADICAND_WIDTH-1){1'b0}}, 1'b1} << (2 * (ROOT_WIDTH - 1));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND,
        ST_OUT
    } state_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic round;
    } ctrl_t;

endpackage

/* hdl/isqrt_unit.sv */
// datapath: remainder, partial root and trial bit, one root bit per step
// depends on isqrt_pkg

module isqrt_unit
(
    input  logic                                      clk,
    input  logic [isqrt_pkg::RADICAND_PORT_WIDTH-1:0] radicand,
    input  isqrt_pkg::ctrl_t                          ctrl,
    output logic [isqrt_pkg::ROOT_PORT_WIDTH-1:0]     root,
    output logic                                      negative_input
);

    logic [isqrt_pkg::RADICAND_WIDTH-1:0] rem_reg, rem_next;
    logic [isqrt_pkg::RADICAND_WIDTH-1:0] acc_reg, acc_next;
    logic [isqrt_pkg::RADICAND_WIDTH-1:0] bit_reg, bit_next;
    logic [isqrt_pkg::ROOT_WIDTH-1:0]     root_reg, root_next;
    logic                                 neg_reg, neg_next;

    logic [isqrt_pkg::RADICAND_WIDTH-1:0] trial;
    logic                                 fits;
    logic [isqrt_pkg::ROOT_WIDTH-1:0]     floor_root;
    logic                                 round_up;

    // acc is a multiple of 4*bit, so or-ing the trial bit is an add
    assign trial      = acc_reg | bit_reg;
    assign fits       = (rem_reg >= trial);
    assign floor_root = acc_reg[isqrt_pkg::ROOT_WIDTH-1:0];
    // rem = n - r*r; nearer to r+1 exactly when rem > r
    assign round_up   = (rem_reg > acc_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        neg_next  = neg_reg;
        if (ctrl.load)
        begin
            rem_next  = radicand[isqrt_pkg::RADICAND_WIDTH-1:0];
            acc_next  = '0;
            bit_next  = isqrt_pkg::BIT_START;
            root_next = '0;
            neg_next  = radicand[isqrt_pkg::RADICAND_WIDTH-1];
        end
        else if (ctrl.step)
        begin
            if (fits)
            begin
                rem_next = rem_reg - trial;
                acc_next = (acc_reg >> 1) | bit_reg;
            end
            else
            begin
                acc_next = acc_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        else if (ctrl.round)
        begin
            root_next = round_up ? floor_root + 1'b1 : floor_root;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
        neg_reg  <= neg_next;
    end

    assign root           = isqrt_pkg::ROOT_PORT_WIDTH'(root_reg);
    assign negative_input = neg_reg;

endmodule

/* hdl/isqrt_ctrl.sv */
// sequencer: handshakes and iteration count for the square root datapath
// depends on isqrt_pkg

module isqrt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             negative,
    output logic             out_valid,
    input  logic             out_ready,
    output isqrt_pkg::ctrl_t ctrl
);

    isqrt_pkg::state_t                state_reg, state_next;
    logic [isqrt_pkg::ITER_WIDTH-1:0] cnt_reg, cnt_next;
    logic                             last_iter;

    assign last_iter = (cnt_reg == isqrt_pkg::ITER_WIDTH'(isqrt_pkg::ROOT_WIDTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            isqrt_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = negative ? isqrt_pkg::ST_OUT : isqrt_pkg::ST_ITER;
                end
            end
            isqrt_pkg::ST_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_iter)
                begin
                    state_next = isqrt_pkg::ST_ROUND;
                end
            end
            isqrt_pkg::ST_ROUND:
            begin
                state_next = isqrt_pkg::ST_OUT;
            end
            isqrt_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = isqrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isqrt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.round = 1'b0;
        case (state_reg)
            isqrt_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            isqrt_pkg::ST_ITER:  ctrl.step  = 1'b1;
            isqrt_pkg::ST_ROUND: ctrl.round = 1'b1;
            isqrt_pkg::ST_OUT:   out_valid  = 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isqrt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* hdl/integer_sqrt_round_nearest.sv */
// top level of the rounded integer square root
// depends on isqrt_pkg, isqrt_ctrl and isqrt_unit

// Takes one signed radicand per item and returns its square root rounded to
// the nearest integer, ties going to the lower value, with negative_input set
// and root 0 when the radicand is negative. Only the low RADICAND_WIDTH bits
// of radicand are used (64 by default). The floor root is found by the
// restoring digit-by-digit method: one shared subtract-and-compare unit
// produces one root bit per cycle, so a non-negative item goes through that
// loop once for each of its ROOT_WIDTH = 32 root bits, then a rounding step,
// and then holds its result in the output register until taken. A negative
// radicand skips the loop: its result is offered in the cycle right after
// acceptance. The block works on one item at a time; in_ready is low from
// acceptance until the result has been taken.

module integer_sqrt_round_nearest
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [isqrt_pkg::RADICAND_PORT_WIDTH-1:0] radicand,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [isqrt_pkg::ROOT_PORT_WIDTH-1:0]     root,
    output logic                                      negative_input
);

    isqrt_pkg::ctrl_t ctrl;

    // sequencer: idle, iteration, rounding and result-hold states
    isqrt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .negative  (radicand[isqrt_pkg::RADICAND_WIDTH-1]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // shared datapath; root and flag registers stay put while out_valid is high
    isqrt_unit u_unit
    (
        .clk            (clk),
        .radicand       (radicand),
        .ctrl           (ctrl),
        .root           (root),
        .negative_input (negative_input)
    );

endmodule

/* hdl/isqrt_checker.sv */
// port-level checks for the rounded integer square root
// depends on isqrt_pkg; bound to integer_sqrt_round_nearest

module isqrt_checker
(
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      in_valid,
    input logic                                      in_ready,
    input logic [isqrt_pkg::RADICAND_PORT_WIDTH-1:0] radicand,
    input logic                                      out_valid,
    input logic                                      out_ready,
    input logic [isqrt_pkg::ROOT_PORT_WIDTH-1:0]     root,
    input logic                                      negative_input
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root) && $stable(negative_input))
        else $error("result changed while stalled");

    // one item at a time
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // an error result carries a zero root
    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && negative_input |-> root == '0)
        else $error("negative radicand gave nonzero root");

    // a negative item finishes right away with the flag set
    a_neg_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && radicand[isqrt_pkg::RADICAND_WIDTH-1]
        |=> out_valid && negative_input)
        else $error("negative radicand not flagged");

    // after a result is taken the block is ready again
    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("block not ready after result taken");

endmodule

bind integer_sqrt_round_nearest isqrt_checker u_isqrt_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .radicand       (radicand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .root           (root),
    .negative_input (negative_input)
);

/* sim/testbench.sv */
// self-checking bench for integer_sqrt_round_nearest, the rounded square root
// needs isqrt_pkg and the block's top level; predicts each root on its own

`timescale 1ns / 1ps

module testbench;

    // one result as the block reports it
    typedef struct packed {
        logic [isqrt_pkg::ROOT_PORT_WIDTH-1:0] root;
        logic                                  negative_input;
    } sqrt_result_t;

    // idle modes, stepped through as items go out
    typedef enum int {
        MODE_STEADY,
        MODE_SENDER_GAPS,
        MODE_RECEIVER_STALLS,
        MODE_BOTH_IDLE
    } idle_mode_t;

    localparam int ITEMS_PER_MODE   = 450;
    localparam int RANDOM_ITEMS     = 1700;
    localparam int PRESSURE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 40;
    localparam logic [63:0] TOP_ROOT = 64'd3037000499;

    logic                                      clk = 1'b0;
    logic                                      rst_n = 1'b0;
    logic                                      in_valid;
    logic                                      in_ready;
    logic [isqrt_pkg::RADICAND_PORT_WIDTH-1:0] radicand;
    logic                                      out_valid;
    logic                                      out_ready;
    logic [isqrt_pkg::ROOT_PORT_WIDTH-1:0]     root;
    logic                                      negative_input;

    // radicands still to offer, and the roots that accepted items will bring
    logic [63:0]  radicand_backlog[$];
    sqrt_result_t pending_roots[$];

    int         items_sent = 0;
    int         items_total = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         hold_left = 0;
    logic       pressure_done = 1'b0;
    idle_mode_t idle_mode;

    integer_sqrt_round_nearest uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .radicand       (radicand),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .root           (root),
        .negative_input (negative_input)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // the mode follows the number of items taken so far, so the directed
    // items and the first stretch of random ones see no idling at all
    always_comb
    begin
        idle_mode = idle_mode_t'((items_sent / ITEMS_PER_MODE) % 4);
    end

    // expected root: digit-by-digit floor root, then round to nearest with
    // ties to the lower value; a negative radicand gives root 0 and the flag
    function automatic sqrt_result_t rounded_root(logic [63:0] raw);
        int unsigned  width;
        int           i;
        logic [63:0]  value;
        logic [63:0]  rem;
        logic [63:0]  acc;
        logic [63:0]  weight;
        logic [63:0]  below;
        logic [63:0]  above;
        sqrt_result_t res;
        width = isqrt_pkg::RADICAND_WIDTH;
        if (width < 8)
            width = 8;
        if (width > 64)
            width = 64;
        // bits above the width play no part
        value = raw & ({64{1'b1}} >> (64 - width));
        res.root = '0;
        res.negative_input = value[width-1];
        if (!res.negative_input)
        begin
            rem = value;
            acc = '0;
            weight = 64'd1 << 62;
            for (i = 0; i < 32; i++)
            begin
                if (rem >= acc + weight)
                begin
                    rem = rem - (acc + weight);
                    acc = (acc >> 1) + weight;
                end
                else
                begin
                    acc = acc >> 1;
                end
                weight = weight >> 2;
            end
            // distances to the two candidate squares, both fit in 64 bits
            below = value - acc * acc;
            above = (acc + 64'd1) * (acc + 64'd1) - value;
            res.root = (below > above) ? acc[31:0] + 32'd1 : acc[31:0];
        end
        return res;
    endfunction

    function automatic logic roll(int unsigned percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    // a radicand near r*r, including the points where rounding flips
    function automatic logic [63:0] near_square();
        logic [63:0] r;
        logic [63:0] sq;
        r = 64'($urandom_range(0, 32'd3037000499) >> $urandom_range(0, 31));
        sq = r * r;
        case ($urandom_range(0, 5))
            0: return sq;
            1: return sq - 64'd1;
            2: return sq + 64'd1;
            3: return sq + r;
            4: return sq + r + 64'd1;
            default: return sq + 64'($urandom_range(0, 2 * 32'(r) + 2));
        endcase
    endfunction

    // random radicands: mostly non-negative ones, which take the long path
    // through the root loop, with negatives and raw noise mixed in
    function automatic logic [63:0] random_radicand();
        int unsigned pick;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            v = {$urandom, $urandom};
        else if (pick < 45)
            v = {$urandom, $urandom} >> $urandom_range(1, 63);
        else if (pick < 70)
            v = near_square();
        else if (pick < 85)
            v = 64'($urandom_range(0, 1000));
        else if (pick < 93)
            v = {1'b1, 31'($urandom), $urandom};
        else
            v = -64'($urandom_range(1, 1000));
        return v;
    endfunction

    // stimulus: directed corners first, then random items
    initial
    begin
        radicand_backlog.push_back(64'd0);
        radicand_backlog.push_back(64'd1);
        radicand_backlog.push_back(64'd2);
        radicand_backlog.push_back(64'd3);
        radicand_backlog.push_back(64'd4);
        radicand_backlog.push_back(64'd6);
        radicand_backlog.push_back(64'd7);
        radicand_backlog.push_back(64'd15);
        radicand_backlog.push_back(64'd16);
        radicand_backlog.push_back(64'd72);
        radicand_backlog.push_back(64'd73);
        radicand_backlog.push_back(64'hffff_ffff);
        radicand_backlog.push_back(64'h1_0000_0000);
        radicand_backlog.push_back(64'h4000_0000_0000_0000);
        radicand_backlog.push_back(64'h3fff_ffff_ffff_ffff);
        // largest root and the values just around its square
        radicand_backlog.push_back(TOP_ROOT * TOP_ROOT);
        radicand_backlog.push_back(TOP_ROOT * TOP_ROOT - 64'd1);
        radicand_backlog.push_back(TOP_ROOT * TOP_ROOT + TOP_ROOT);
        radicand_backlog.push_back(TOP_ROOT * TOP_ROOT + TOP_ROOT + 64'd1);
        radicand_backlog.push_back(64'h7fff_ffff_ffff_fffe);
        radicand_backlog.push_back(64'h7fff_ffff_ffff_ffff);
        // negative side: most negative, minus one, a random one
        radicand_backlog.push_back(64'h8000_0000_0000_0000);
        radicand_backlog.push_back(64'hffff_ffff_ffff_ffff);
        radicand_backlog.push_back(64'hdead_beef_0123_4567);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            radicand_backlog.push_back(random_radicand());
        items_total = radicand_backlog.size();
    end

    // driver: offers the front of the backlog, holds it until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            radicand <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                void'(radicand_backlog.pop_front());
                items_sent <= items_sent + 1;
            end
            if (radicand_backlog.size() > 0 &&
                !((idle_mode == MODE_SENDER_GAPS && roll(46)) ||
                  (idle_mode == MODE_BOTH_IDLE && roll(22))))
            begin
                in_valid <= 1'b1;
                radicand <= radicand_backlog[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off early in the
    // receiver-stall mode while the driver keeps offering items, so the
    // block sits on a finished result with its input blocked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            pressure_done <= 1'b0;
        end
        else if (!pressure_done && idle_mode == MODE_RECEIVER_STALLS)
        begin
            out_ready <= 1'b0;
            hold_left <= PRESSURE_CYCLES;
            pressure_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_ready <= !((idle_mode == MODE_RECEIVER_STALLS && roll(46)) ||
                           (idle_mode == MODE_BOTH_IDLE && roll(22)));
        end
    end

    // monitor: predicts on each accepted item, checks each accepted result
    always @(posedge clk)
    begin
        sqrt_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_roots.push_back(rounded_root(radicand));
            if (out_valid && out_ready)
            begin
                if (pending_roots.size() == 0)
                begin
                    $error("result with no item outstanding: root %0d negative_input %0b",
                           root, negative_input);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_roots.pop_front();
                    if (root !== want.root)
                    begin
                        $error("root: expected %0d, got %0d", want.root, root);
                        mismatch_count++;
                    end
                    if (negative_input !== want.negative_input)
                    begin
                        $error("negative_input: expected %0b, got %0b",
                               want.negative_input, negative_input);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // reset once, then wait for every item to go in and every root to come out
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (items_total == 0 || items_sent < items_total || pending_roots.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_roots.size() > 0)
        begin
            $error("%0d roots never arrived", pending_roots.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
